/* design/sfq_pkg.sv */
// sfq_pkg: shared constants, codes, types and the crc-8 step for the frame queue
// no dependencies; imported by every module of the block
`default_nettype none

package sfq_pkg;

	localparam int QUEUE_DEPTH = 4096;
	localparam int MAX_SEGMENT = 1024;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W  = 11;
	localparam int SEG_CMP_W = 17;
	localparam int CMP_W  = (FILL_W > LEN_W + 1) ? FILL_W : LEN_W + 1;

	localparam logic [7:0] SOF_BYTE    = 8'hAA;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam int         FRAME_EXTRA = 5;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_DRAIN   = 2'd2;

	typedef enum logic [2:0] {
		ST_FRAME_OK     = 3'd0,
		ST_FRAME_DROP   = 3'd1,
		ST_EMPTY_HDR    = 3'd2,
		ST_STORED       = 3'd3,
		ST_DISCARDED    = 3'd4,
		ST_DRAINED      = 3'd5,
		ST_QUEUE_EMPTY  = 3'd6,
		ST_OUT_OF_ORDER = 3'd7
	} sfq_status_t;

	// append request from the decode logic to the ring
	typedef struct packed {
		logic       en;
		logic       hdr;
		logic       tail_crc;
		logic [7:0] first;
		logic [7:0] src;
		logic [7:0] len_hi;
		logic [7:0] len_lo;
	} sfq_wreq_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] v);
		logic [7:0] r;
		r = c ^ v;
		for (int b = 0; b < 8; b++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
		logic [ADDR_W-1:0] n;
		if (p == ADDR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + ADDR_W'(1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

/* design/sfq_ring.sv */
// sfq_ring: byte ring memory with burst append sequencer and running crc-8
// depends on sfq_pkg
`default_nettype none

module sfq_ring (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfq_pkg::sfq_wreq_t wreq,
	input  wire logic              pop,
	output logic                   busy,
	output logic [7:0]             rd_byte
);
	import sfq_pkg::*;

	logic [7:0]        mem_q [QUEUE_DEPTH];
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] rp_q;
	logic [7:0]        pend_q [3];
	logic [1:0]        pend_cnt_q;
	logic [7:0]        crc_q;
	logic [7:0]        rd_byte_q;

	logic       wr_en;
	logic [7:0] wr_data;
	logic [7:0] crc_first;

	assign busy      = (pend_cnt_q != 2'd0);
	assign wr_en     = wreq.en || busy;
	assign wr_data   = wreq.en ? wreq.first : pend_q[0];
	assign crc_first = crc8_step(crc_q, wreq.first);
	assign rd_byte   = rd_byte_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
		if (pop) begin
			rd_byte_q <= mem_q[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wreq.en) begin
			if (wreq.hdr) begin
				pend_q[0] <= wreq.src;
				pend_q[1] <= wreq.len_hi;
				pend_q[2] <= wreq.len_lo;
			end else begin
				pend_q[0] <= crc_first;
			end
		end else if (busy) begin
			pend_q[0] <= pend_q[1];
			pend_q[1] <= pend_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			pend_cnt_q <= 2'd0;
			crc_q      <= 8'd0;
		end else begin
			if (wr_en) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			if (wreq.en) begin
				if (wreq.hdr) begin
					// start byte stays out of the crc
					crc_q      <= 8'd0;
					pend_cnt_q <= 2'd3;
				end else begin
					crc_q      <= crc_first;
					pend_cnt_q <= wreq.tail_crc ? 2'd1 : 2'd0;
				end
			end else if (busy) begin
				crc_q      <= crc8_step(crc_q, pend_q[0]);
				pend_cnt_q <= pend_cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/sof_length_crc8_frame_queue_top.sv */
// Frame queue with start byte, 16-bit length and crc-8 over two receive channels.
// Input channel in_valid/in_stall carries kind, channel, seg_length, data_byte;
// a transaction completes on a rising edge with valid high and stall low. The
// result channel res_valid/res_stall carries one result per input transaction,
// in order, with out_valid, out_byte, status, queue_fill and the three counters.
// A result is registered in the first stage, then in the output register.
// Drain, discarded payload and mid-frame payload write at most one queue byte; a
// payload byte that closes a frame writes two (data byte and crc byte); an accepted
// header writes four, one per header byte, as the queue memory has one write port.
// in_stall is held while those extra bytes are written.
// A finished result waits in the output register while the next transaction is
// taken into the first stage; with both full and res_stall high, in_stall rises.
// Reset (arst_n low) empties the queue, closes any frame and clears all counters;
// the queue memory itself is not cleared, only entries written are ever read.
// depends on sfq_pkg and sfq_ring
`default_nettype none

module sof_length_crc8_frame_queue_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               kind,
	input  wire logic                     channel,
	input  wire logic [sfq_pkg::LEN_W-1:0] seg_length,
	input  wire logic [7:0]               data_byte,
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic                          out_valid,
	output logic [7:0]                    out_byte,
	output logic [2:0]                    status,
	output logic [sfq_pkg::FILL_W-1:0]    queue_fill,
	output logic [31:0]                   dropped_bytes,
	output logic [31:0]                   dropped_frames,
	output logic [31:0]                   received_bytes
);
	import sfq_pkg::*;

	// control state
	logic [FILL_W-1:0] fill_q;
	logic              open_q;
	logic              disc_q;
	logic [LEN_W-1:0]  rem_q;
	logic [31:0]       drop_bytes_q;
	logic [31:0]       drop_frames_q;
	logic [31:0]       chan_q [2];

	// first stage
	logic              v_s1;
	logic              pop_s1;
	sfq_status_t       status_s1;
	logic [FILL_W-1:0] fill_s1;
	logic [31:0]       drop_bytes_s1;
	logic [31:0]       drop_frames_s1;
	logic [31:0]       recv_s1;

	// output register
	logic              res_v_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	sfq_status_t       status_q;
	logic [FILL_W-1:0] fill_out_q;
	logic [31:0]       drop_bytes_out_q;
	logic [31:0]       drop_frames_out_q;
	logic [31:0]       recv_out_q;

	logic              acc;
	logic              adv_s1;
	logic              busy;
	logic [7:0]        rd_byte;
	sfq_wreq_t         wreq;
	logic              pop;

	logic [LEN_W-1:0]  len;
	logic [15:0]       len16;
	logic [CMP_W-1:0]  need;
	logic [CMP_W-1:0]  space;

	logic [FILL_W-1:0] fill_n;
	logic              open_n;
	logic              disc_n;
	logic [LEN_W-1:0]  rem_n;
	logic [31:0]       drop_bytes_n;
	logic [31:0]       drop_frames_n;
	logic [31:0]       chan_n;
	sfq_status_t       st;

	assign adv_s1   = v_s1 && (!res_v_q || !res_stall);
	assign in_stall = busy || (v_s1 && !adv_s1);
	assign acc      = in_valid && !in_stall;

	assign len   = (SEG_CMP_W'(seg_length) > SEG_CMP_W'(MAX_SEGMENT))
	               ? LEN_W'(MAX_SEGMENT) : seg_length;
	assign len16 = 16'(len);
	assign need  = CMP_W'(len) + CMP_W'(FRAME_EXTRA);
	assign space = CMP_W'(QUEUE_DEPTH) - CMP_W'(fill_q);

	always_comb begin
		fill_n        = fill_q;
		open_n        = open_q;
		disc_n        = disc_q;
		rem_n         = rem_q;
		drop_bytes_n  = drop_bytes_q;
		drop_frames_n = drop_frames_q;
		chan_n        = chan_q[channel];
		st            = ST_OUT_OF_ORDER;
		pop           = 1'b0;
		wreq          = '0;
		wreq.first    = data_byte;
		wreq.src      = 8'(channel) + 8'd1;
		wreq.len_hi   = len16[15:8];
		wreq.len_lo   = len16[7:0];
		case (kind)
			KIND_HEADER: begin
				if (!open_q && !disc_q) begin
					if (len == '0) begin
						st = ST_EMPTY_HDR;
					end else begin
						chan_n = chan_q[channel] + 32'(len);
						rem_n  = len;
						if (need > space) begin
							drop_bytes_n  = drop_bytes_q + 32'(need);
							drop_frames_n = drop_frames_q + 32'd1;
							disc_n        = 1'b1;
							st            = ST_FRAME_DROP;
						end else begin
							wreq.en    = 1'b1;
							wreq.hdr   = 1'b1;
							wreq.first = SOF_BYTE;
							fill_n     = fill_q + FILL_W'(4);
							open_n     = 1'b1;
							st         = ST_FRAME_OK;
						end
					end
				end
			end
			KIND_PAYLOAD: begin
				if (open_q) begin
					wreq.en = 1'b1;
					rem_n   = rem_q - LEN_W'(1);
					if (rem_q == LEN_W'(1)) begin
						// last payload byte: crc byte follows
						wreq.tail_crc = 1'b1;
						fill_n        = fill_q + FILL_W'(2);
						open_n        = 1'b0;
					end else begin
						fill_n = fill_q + FILL_W'(1);
					end
					st = ST_STORED;
				end else if (disc_q) begin
					rem_n = rem_q - LEN_W'(1);
					if (rem_q == LEN_W'(1)) begin
						disc_n = 1'b0;
					end
					st = ST_DISCARDED;
				end
			end
			KIND_DRAIN: begin
				if (fill_q == '0) begin
					st = ST_QUEUE_EMPTY;
				end else begin
					pop    = 1'b1;
					fill_n = fill_q - FILL_W'(1);
					st     = ST_DRAINED;
				end
			end
			default: begin
				st = ST_OUT_OF_ORDER;
			end
		endcase
		wreq.en = wreq.en && acc;
		pop     = pop && acc;
	end

	sfq_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wreq    (wreq),
		.pop     (pop),
		.busy    (busy),
		.rd_byte (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			open_q        <= 1'b0;
			disc_q        <= 1'b0;
			rem_q         <= '0;
			drop_bytes_q  <= 32'd0;
			drop_frames_q <= 32'd0;
			chan_q[0]     <= 32'd0;
			chan_q[1]     <= 32'd0;
			v_s1          <= 1'b0;
			res_v_q       <= 1'b0;
		end else begin
			if (acc) begin
				fill_q          <= fill_n;
				open_q          <= open_n;
				disc_q          <= disc_n;
				rem_q           <= rem_n;
				drop_bytes_q    <= drop_bytes_n;
				drop_frames_q   <= drop_frames_n;
				chan_q[channel] <= chan_n;
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_v_q <= 1'b1;
			end else if (!res_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_s1         <= pop;
			status_s1      <= st;
			fill_s1        <= fill_n;
			drop_bytes_s1  <= drop_bytes_n;
			drop_frames_s1 <= drop_frames_n;
			recv_s1        <= chan_n;
		end
		if (adv_s1) begin
			// read data of a drain is held in the ring until the next drain
			out_valid_q       <= pop_s1;
			out_byte_q        <= pop_s1 ? rd_byte : 8'd0;
			status_q          <= status_s1;
			fill_out_q        <= fill_s1;
			drop_bytes_out_q  <= drop_bytes_s1;
			drop_frames_out_q <= drop_frames_s1;
			recv_out_q        <= recv_s1;
		end
	end

	assign res_valid      = res_v_q;
	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign status         = status_q;
	assign queue_fill     = fill_out_q;
	assign dropped_bytes  = drop_bytes_out_q;
	assign dropped_frames = drop_frames_out_q;
	assign received_bytes = recv_out_q;

endmodule

`default_nettype wire

/* design/sfq_port_check.sv */
// sfq_port_check: checks on the result channel seen at the top level ports
// depends on sfq_pkg; bound to sof_length_crc8_frame_queue_top below
`default_nettype none

module sfq_port_check (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     res_valid,
	input wire logic                     res_stall,
	input wire logic                     out_valid,
	input wire logic [7:0]               out_byte,
	input wire logic [2:0]               status,
	input wire logic [sfq_pkg::FILL_W-1:0] queue_fill
);
	import sfq_pkg::*;

	// a popped byte is reported exactly on a drain
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (out_valid == (status == ST_DRAINED)))
		else $error("out_valid disagrees with status");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_byte == 8'd0))
		else $error("out_byte not zero without a popped byte");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (status == ST_QUEUE_EMPTY)) |-> (queue_fill == '0))
		else $error("queue reported empty with bytes held");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(status) && $stable(queue_fill)))
		else $error("stalled result transaction changed");

endmodule

bind sof_length_crc8_frame_queue_top sfq_port_check u_port_check (.*);

`default_nettype wire
